>>> hw/rtl/rlcs_pkg.sv
// ----------------------------------------------------------------------------
// rlcs_pkg
// Shared types, constants and helpers of the RGB LED chain serializer.
// ----------------------------------------------------------------------------
package rlcs_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int PULSE_W     = 16;
	localparam int TIME_W      = 20;
	localparam int COLOUR_W    = 24;
	localparam int COUNT_W     = 8;
	localparam int BIT_IDX_W   = 5;

	localparam logic [BIT_IDX_W-1:0] LAST_BIT = 5'd23;

	localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LATCH_LOW = 3'd4;

	localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = 16'd100;
	localparam logic [PULSE_W-1:0] ONE_LOW_RST   = 16'd24;
	localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = 16'd24;
	localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = 16'd100;
	localparam logic [TIME_W-1:0]  LATCH_LOW_RST = 20'd40000;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2,
		PH_LATCH = 2'd3
	} phase_t;

	typedef struct packed {
		logic                start;
		logic [COLOUR_W-1:0] colour;
		logic [COUNT_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic [PULSE_W-1:0] one_high;
		logic [PULSE_W-1:0] one_low;
		logic [PULSE_W-1:0] zero_high;
		logic [PULSE_W-1:0] zero_low;
		logic [TIME_W-1:0]  latch_low;
	} timing_t;

	typedef struct packed {
		logic rejected;
		logic frame_done;
		logic busy_res;
		logic pin_level;
	} result_t;

	// A programmed length of zero counts as one tick.
	function automatic logic [TIME_W-1:0] pulse_len(input logic [PULSE_W-1:0] v);
		logic [TIME_W-1:0] ext;
		ext = TIME_W'(v);
		return (v == '0) ? TIME_W'(1) : ext;
	endfunction

	function automatic logic [TIME_W-1:0] latch_len(input logic [TIME_W-1:0] v);
		return (v == '0) ? TIME_W'(1) : v;
	endfunction

endpackage

>>> hw/rtl/rlcs_front.sv
// ----------------------------------------------------------------------------
// rlcs_front
// Accepts input items, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module rlcs_front #(
	parameter int QueueDepth = rlcs_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,
	input  logic                 s_tuser,
	output logic                 cmd_valid,
	input  logic                 cmd_pop,
	output rlcs_pkg::cmd_t       cmd
);
	import rlcs_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	cmd_t            mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	cmd_t            in_cmd;
	logic            push;
	logic            pop;

	always_comb begin
		in_cmd.start  = s_tuser;
		in_cmd.colour = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
		in_cmd.count  = s_tdata[31:24];
	end

	assign s_tready  = (count_q != CntW'(QueueDepth));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/rlcs_back.sv
// ----------------------------------------------------------------------------
// rlcs_back
// Runs the waveform state machine on queued commands, one per cycle unless
// the receiver stalls, and holds each result in an output register.
// ----------------------------------------------------------------------------
module rlcs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  rlcs_pkg::cmd_t    cmd,
	input  rlcs_pkg::timing_t timing,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata
);
	import rlcs_pkg::*;

	phase_t               phase_q, phase_d;
	logic [COLOUR_W-1:0]  colour_q, colour_d;
	logic [COLOUR_W-1:0]  shift_q, shift_d;
	logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
	logic [COUNT_W-1:0]   leds_q, leds_d;
	logic [TIME_W-1:0]    time_q, time_d;
	logic [TIME_W-1:0]    time_m1;
	logic                 seg_end;
	logic                 last_bit;
	logic                 last_led;
	logic                 done;
	logic                 rej;
	logic                 out_valid_q;
	result_t              out_q;
	result_t              res;

	assign cmd_pop  = cmd_valid && (!out_valid_q || m_tready);
	assign time_m1  = time_q - 1'b1;
	assign seg_end  = (time_m1 == '0);
	assign last_bit = (bit_idx_q >= LAST_BIT);
	assign last_led = (leds_q == COUNT_W'(1));

	// Next phase and per-item flags.
	always_comb begin
		phase_d = phase_q;
		done    = 1'b0;
		rej     = 1'b0;
		if (cmd.start) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				phase_d = (cmd.count == '0) ? PH_LATCH : PH_HIGH;
			end
		end else if (phase_q != PH_IDLE && seg_end) begin
			case (phase_q)
				PH_HIGH: begin
					phase_d = PH_LOW;
				end
				PH_LOW: begin
					phase_d = (last_bit && last_led) ? PH_LATCH : PH_HIGH;
				end
				PH_LATCH: begin
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Datapath: counters, shift word and segment lengths.
	always_comb begin
		colour_d  = colour_q;
		shift_d   = shift_q;
		bit_idx_d = bit_idx_q;
		leds_d    = leds_q;
		time_d    = time_q;
		if (cmd.start) begin
			if (phase_q == PH_IDLE) begin
				colour_d = cmd.colour;
				leds_d   = cmd.count;
				if (cmd.count == '0) begin
					time_d = latch_len(timing.latch_low);
				end else begin
					shift_d   = cmd.colour;
					bit_idx_d = '0;
					time_d    = pulse_len(cmd.colour[COLOUR_W-1] ?
						timing.one_high : timing.zero_high);
				end
			end
		end else if (phase_q != PH_IDLE) begin
			time_d = time_m1;
			if (seg_end) begin
				case (phase_q)
					PH_HIGH: begin
						time_d = pulse_len(shift_q[COLOUR_W-1] ?
							timing.one_low : timing.zero_low);
					end
					PH_LOW: begin
						if (last_bit) begin
							leds_d = leds_q - 1'b1;
							if (last_led) begin
								time_d = latch_len(timing.latch_low);
							end else begin
								shift_d   = colour_q;
								bit_idx_d = '0;
								time_d    = pulse_len(colour_q[COLOUR_W-1] ?
									timing.one_high : timing.zero_high);
							end
						end else begin
							bit_idx_d = bit_idx_q + 1'b1;
							shift_d   = {shift_q[COLOUR_W-2:0], 1'b0};
							time_d    = pulse_len(shift_q[COLOUR_W-2] ?
								timing.one_high : timing.zero_high);
						end
					end
					PH_LATCH: begin
						time_d = '0;
					end
					default: begin
						time_d = '0;
					end
				endcase
			end
		end
	end

	always_comb begin
		res.pin_level  = (phase_d == PH_HIGH);
		res.busy_res   = (phase_d != PH_IDLE);
		res.frame_done = done;
		res.rejected   = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			colour_q  <= '0;
			shift_q   <= '0;
			bit_idx_q <= '0;
			leds_q    <= '0;
			time_q    <= '0;
		end else if (cmd_pop) begin
			phase_q   <= phase_d;
			colour_q  <= colour_d;
			shift_q   <= shift_d;
			bit_idx_q <= bit_idx_d;
			leds_q    <= leds_d;
			time_q    <= time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q};

endmodule

>>> hw/rtl/rgb_led_chain_serializer_top.sv
// ----------------------------------------------------------------------------
// rgb_led_chain_serializer_top
// Single-wire addressable RGB LED chain serializer.
//
// Each input item is either a tick (s_tuser = 0), which advances the data
// line waveform by one time step, or a start (s_tuser = 1), which latches a
// colour and an LED count from s_tdata and begins a frame. Every item gives
// exactly one result item on the master side: line level, busy, frame done
// and a flag for a start that arrived while a frame was running.
// Pulse widths and the latch period come from the write-only register port.
// An item is taken every cycle while the queue is not full. An accepted item
// is written into the command queue, and the state machine then writes its
// result into the output register, which drives m_tvalid. The state machine
// updates its state once per item and sets the rate of one per cycle while
// the receiver keeps up.
// When the receiver stalls, the output register holds its result and the
// queue fills; s_tready drops only once the queue is full.
// Reset clears the queue, the state machine (line low, idle) and loads the
// default pulse widths.
// ----------------------------------------------------------------------------
module rgb_led_chain_serializer_top #(
	parameter int QueueDepth = rlcs_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// green [7:0], red [15:8], blue [23:16], led_count [31:24]
	input  logic [31:0]                        s_tdata,
	// operation: 0 = tick, 1 = start a frame
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pin_level [0], busy_res [1], frame_done [2], rejected [3], zero [7:4]
	output logic [7:0]                         m_tdata,
	input  logic                               cfg_we,
	input  logic [rlcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rlcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rlcs_pkg::*;

	timing_t timing_q;
	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.one_high  <= ONE_HIGH_RST;
			timing_q.one_low   <= ONE_LOW_RST;
			timing_q.zero_high <= ZERO_HIGH_RST;
			timing_q.zero_low  <= ZERO_LOW_RST;
			timing_q.latch_low <= LATCH_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ONE_HIGH:  timing_q.one_high  <= cfg_data[PULSE_W-1:0];
				REG_ONE_LOW:   timing_q.one_low   <= cfg_data[PULSE_W-1:0];
				REG_ZERO_HIGH: timing_q.zero_high <= cfg_data[PULSE_W-1:0];
				REG_ZERO_LOW:  timing_q.zero_low  <= cfg_data[PULSE_W-1:0];
				REG_LATCH_LOW: timing_q.latch_low <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rlcs_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd)
	);

	rlcs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.timing   (timing_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> tb/sv/rlcs_line_checker.sv
// ----------------------------------------------------------------------------
// rlcs_line_checker
// Watches the input, result and register write channels of the LED chain
// serializer. It keeps its own copy of the pulse widths and of the waveform
// state, works out the line level, busy, frame done and rejected flags for
// every accepted input item, and compares each result item in order.
// ----------------------------------------------------------------------------
module rlcs_line_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// green [7:0], red [15:8], blue [23:16], led_count [31:24]
	input  logic [31:0]                      s_tdata,
	// operation: 0 = tick, 1 = start a frame
	input  logic                             s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// pin_level [0], busy_res [1], frame_done [2], rejected [3], zero [7:4]
	input  logic [7:0]                       m_tdata,
	input  logic                             cfg_we,
	input  logic [rlcs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rlcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatches,
	output int                               outstanding
);

	import rlcs_pkg::*;

	timing_t              timing;
	logic [COLOUR_W-1:0]  colour;
	logic [COLOUR_W-1:0]  shifter;
	logic [BIT_IDX_W-1:0] bit_pos;
	logic [COUNT_W-1:0]   leds_to_go;
	phase_t               line_phase;
	logic [TIME_W-1:0]    ticks_left;
	result_t              expected_levels[$];
	int                   results_seen;

	function automatic logic [TIME_W-1:0] seg_ticks(input logic [PULSE_W-1:0] v);
		return (v == '0) ? TIME_W'(1) : TIME_W'(v);
	endfunction

	task automatic log_mismatch(input string msg);
		if (mismatches < 50) begin
			$display("MISMATCH at result %0d: %s", results_seen, msg);
		end
		mismatches++;
	endtask

	task automatic load_high();
		line_phase = PH_HIGH;
		ticks_left = seg_ticks(shifter[COLOUR_W-1] ? timing.one_high : timing.zero_high);
	endtask

	task automatic load_low();
		line_phase = PH_LOW;
		ticks_left = seg_ticks(shifter[COLOUR_W-1] ? timing.one_low : timing.zero_low);
	endtask

	task automatic begin_led_word();
		shifter = colour;
		bit_pos = '0;
		load_high();
	endtask

	task automatic begin_latch_low();
		line_phase = PH_LATCH;
		ticks_left = (timing.latch_low == '0) ? TIME_W'(1) : timing.latch_low;
	endtask

	task automatic clear_model();
		timing.one_high  = ONE_HIGH_RST;
		timing.one_low   = ONE_LOW_RST;
		timing.zero_high = ZERO_HIGH_RST;
		timing.zero_low  = ZERO_LOW_RST;
		timing.latch_low = LATCH_LOW_RST;
		colour = '0;
		shifter = '0;
		bit_pos = '0;
		leds_to_go = '0;
		line_phase = PH_IDLE;
		ticks_left = '0;
		expected_levels.delete();
	endtask

	task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_ONE_HIGH: timing.one_high = v[PULSE_W-1:0];
			REG_ONE_LOW: timing.one_low = v[PULSE_W-1:0];
			REG_ZERO_HIGH: timing.zero_high = v[PULSE_W-1:0];
			REG_ZERO_LOW: timing.zero_low = v[PULSE_W-1:0];
			REG_LATCH_LOW: timing.latch_low = v[TIME_W-1:0];
			default: ;
		endcase
	endtask

	task automatic advance_line(input logic op, input logic [31:0] data, output result_t res);
		res = '0;
		if (op) begin
			if (line_phase != PH_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				colour = {data[7:0], data[15:8], data[23:16]};
				leds_to_go = data[31:24];
				if (leds_to_go == '0) begin
					begin_latch_low();
				end else begin
					begin_led_word();
				end
			end
		end else if (line_phase != PH_IDLE) begin
			ticks_left = ticks_left - 1'b1;
			if (ticks_left == '0) begin
				case (line_phase)
					PH_HIGH: load_low();
					PH_LOW: begin
						if (bit_pos >= LAST_BIT) begin
							leds_to_go = leds_to_go - 1'b1;
							if (leds_to_go == '0) begin
								begin_latch_low();
							end else begin
								begin_led_word();
							end
						end else begin
							bit_pos = bit_pos + 1'b1;
							shifter = shifter << 1;
							load_high();
						end
					end
					default: begin
						line_phase = PH_IDLE;
						ticks_left = '0;
						res.frame_done = 1'b1;
					end
				endcase
			end
		end
		res.pin_level = (line_phase == PH_HIGH);
		res.busy_res = (line_phase != PH_IDLE);
	endtask

	task automatic compare_result(input logic [7:0] got);
		result_t want;
		result_t seen;
		if (expected_levels.size() == 0) begin
			log_mismatch($sformatf("result %02h arrived with nothing expected", got));
		end else begin
			want = expected_levels.pop_front();
			seen = got[3:0];
			if (seen.pin_level != want.pin_level)
				log_mismatch($sformatf("pin_level %b, expected %b", seen.pin_level,
					want.pin_level));
			if (seen.busy_res != want.busy_res)
				log_mismatch($sformatf("busy_res %b, expected %b", seen.busy_res,
					want.busy_res));
			if (seen.frame_done != want.frame_done)
				log_mismatch($sformatf("frame_done %b, expected %b", seen.frame_done,
					want.frame_done));
			if (seen.rejected != want.rejected)
				log_mismatch($sformatf("rejected %b, expected %b", seen.rejected,
					want.rejected));
			if (got[7:4] != '0)
				log_mismatch($sformatf("padding bits %h are not zero", got[7:4]));
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		result_t next_res;
		if (!arst_n) begin
			clear_model();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_result(m_tdata);
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				advance_line(s_tuser, s_tdata, next_res);
				expected_levels.push_back(next_res);
			end
			outstanding <= expected_levels.size();
		end
	end

endmodule

>>> tb/sv/rgb_led_chain_serializer_top_test.sv
// ----------------------------------------------------------------------------
// rgb_led_chain_serializer_top_test
// Drives the LED chain serializer with start and tick items under random
// sender gaps and receiver stalls, across several pulse width settings from
// the reset values down to the shortest and up to the longest. A checker
// beside the block predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module rgb_led_chain_serializer_top_test;

	import rlcs_pkg::*;

	localparam int HOLDOFF_CYCLES = 300;
	localparam int STALL_LIMIT    = 5000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [7:0]             m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int mismatches;
	int outstanding;
	int holdoff_req = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	int items_sent = 0;
	int eff_one_high = 100;
	int eff_one_low = 24;
	int eff_zero_high = 24;
	int eff_zero_low = 100;
	int eff_latch = 40000;

	always #1 clk = ~clk;

	rgb_led_chain_serializer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	rlcs_line_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : receiver
		int holds_done;
		int mode;
		int mode_left;
		int beat;
		holds_done = 0;
		mode = 0;
		mode_left = 0;
		beat = 0;
		forever begin
			@(posedge clk);
			if (holdoff_req != holds_done) begin
				holds_done = holdoff_req;
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 64);
			end
			mode_left--;
			beat++;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (beat % 4 == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic push_item(input logic op, input logic [31:0] data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic launch_frame(input logic [7:0] g, r, b, count);
		push_item(1'b1, {count, b, r, g});
	endtask

	task automatic send_ticks(input int n);
		int k;
		for (k = 0; k < n; k++)
			push_item(1'b0, $urandom);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic int pulse_ticks(input logic [CFG_DATA_W-1:0] v);
		return (v[PULSE_W-1:0] == '0) ? 1 : int'(v[PULSE_W-1:0]);
	endfunction

	function automatic int frame_ticks(input int count);
		int hi;
		int lo;
		hi = (eff_one_high > eff_zero_high) ? eff_one_high : eff_zero_high;
		lo = (eff_one_low > eff_zero_low) ? eff_one_low : eff_zero_low;
		return count * COLOUR_W * (hi + lo) + eff_latch;
	endfunction

	task automatic program_timing(input logic [CFG_DATA_W-1:0] one_hi, one_lo, zero_hi,
			zero_lo, latch_lo);
		logic [CFG_INDEX_W-1:0] idx [5];
		logic [CFG_DATA_W-1:0]  val [5];
		int i;
		idx = '{REG_ONE_HIGH, REG_ONE_LOW, REG_ZERO_HIGH, REG_ZERO_LOW, REG_LATCH_LOW};
		val = '{one_hi, one_lo, zero_hi, zero_lo, latch_lo};
		for (i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		// An index past the last register must leave every width unchanged.
		cfg_we <= 1'b1;
		cfg_index <= REG_LATCH_LOW + CFG_INDEX_W'($urandom_range(1, 3));
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_one_high = pulse_ticks(one_hi);
		eff_one_low = pulse_ticks(one_lo);
		eff_zero_high = pulse_ticks(zero_hi);
		eff_zero_low = pulse_ticks(zero_lo);
		eff_latch = (latch_lo == '0) ? 1 : int'(latch_lo);
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_pulse();
		return CFG_DATA_W'($urandom_range(0, 4)) |
			(($urandom_range(0, 3) == 0) ? CFG_DATA_W'(20'h10000) : '0);
	endfunction

	task automatic random_frames(input int target);
		int goal;
		int pick;
		int count;
		int span;
		int k;
		goal = items_sent + target;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 9);
			count = (pick < 2) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
			push_item(1'b1, {8'(count), 24'($urandom)});
			span = frame_ticks(count);
			span = $urandom_range(span * 3 / 4, span + 8);
			for (k = 0; k < span; k++) begin
				if ($urandom_range(0, 60) == 0)
					push_item(1'b1, $urandom);
				else
					push_item(1'b0, $urandom);
			end
		end
	endtask

	initial begin : stimulus
		int phase_no;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset widths: idle ticks, a one bit and a zero bit, a start while busy.
		push_item(1'b0, 32'hFFFF_FFFF);
		push_item(1'b0, 32'h0000_0000);
		launch_frame(8'h80, 8'h00, 8'h01, 8'd1);
		push_item(1'b1, 32'hFFFF_FFFF);
		send_ticks(130);

		// New widths written while the frame still runs apply from the next segment.
		settle();
		program_timing(20'd3, 20'h10000, 20'd1, 20'd2, 20'd4);
		send_ticks(150);

		launch_frame(8'h5A, 8'hA5, 8'h3C, 8'd0);
		push_item(1'b1, 32'hFFFF_FFFF);
		send_ticks(6);
		launch_frame(8'hFF, 8'hFF, 8'hFF, 8'd2);
		send_ticks(frame_ticks(2) + 3);
		launch_frame(8'h00, 8'h00, 8'h00, 8'd1);
		send_ticks(frame_ticks(1) + 3);

		// Zero widths count as a single tick.
		settle();
		program_timing(20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
		launch_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd1);
		send_ticks(frame_ticks(1) + 2);
		launch_frame(8'h00, 8'h00, 8'h00, 8'd0);
		send_ticks(3);

		for (phase_no = 0; phase_no < 5; phase_no++) begin
			settle();
			program_timing(random_pulse(), random_pulse(), random_pulse(), random_pulse(),
				CFG_DATA_W'($urandom_range(0, 24)));
			if (phase_no == 1 || phase_no == 3)
				holdoff_req <= holdoff_req + 1;
			random_frames(100);
		end

		// Longest widths and a full LED count; the frame is left running.
		settle();
		program_timing(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		launch_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_item(1'b1, $urandom);
		send_ticks(200);
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
